/* rtl/core/rsxyz_pkg.sv */
`timescale 1ns / 1ps
package rsxyz_pkg;

   localparam int BEAMS_DEF    = 361;
   localparam int CORDIC_STEPS = 24;
   localparam int XW           = 34;   // CORDIC x/y width, Q2.30 plus headroom
   localparam int ZW           = 33;   // CORDIC residual angle width, 2^30 = 90 deg
   localparam int CSR_IW       = 8;

   localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
   localparam logic [15:0]          COORD_MAX   = 16'hFFFF;

   localparam logic [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      33'h20000000, 33'h12E4051E, 33'h09FB385B, 33'h051111D4,
      33'h028B0D43, 33'h0145D7E1, 33'h00A2F61E, 33'h00517C55,
      33'h0028BE53, 33'h00145F2F, 33'h000A2F98, 33'h000517CC,
      33'h00028BE6, 33'h000145F3, 33'h0000A2FA, 33'h0000517D,
      33'h000028BE, 33'h0000145F, 33'h00000A30, 33'h00000518,
      33'h0000028C, 33'h00000146, 33'h000000A3, 33'h00000051
   };

   // register indexes
   localparam logic [CSR_IW-1:0] REG_BEAM_STEP  = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] REG_START_ANG  = CSR_IW'(1);
   localparam logic [CSR_IW-1:0] REG_MOTOR_RATE = CSR_IW'(2);
   localparam logic [CSR_IW-1:0] REG_DIRECTION  = CSR_IW'(3);

   localparam int ANGLE_LAT  = 2;
   localparam int CORDIC_LAT = CORDIC_STEPS + 2;
   localparam int SCALE_LAT  = 3;
   localparam int LATENCY    = ANGLE_LAT + CORDIC_LAT + SCALE_LAT;

   typedef struct packed {
      logic        valid;
      logic        ok;
      logic [15:0] range;
      logic [15:0] el;
      logic [15:0] az;
   } angle_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } rot_type;

   typedef struct packed {
      logic                 valid;
      logic                 ok;
      logic [15:0]          range;
      logic signed [XW-1:0] ce;
      logic signed [XW-1:0] se;
      logic signed [XW-1:0] ca;
      logic signed [XW-1:0] sa;
   } trig_type;

endpackage

/* rtl/core/rotating_scan_point_to_xyz.sv */
`timescale 1ns / 1ps
// channel   ports                                         handshake
// request   req_range_mm, req_beam_index, req_frame_time  start & !busy
// response  rsp_point_x, rsp_point_y, rsp_point_z         rsp_strobe, one cycle
// csr       csr_index, csr_wdata                          csr_valid & csr_ready
//
// One item per cycle; each point passes through the 24 CORDIC iteration
// stages plus angle (2), CORDIC entry/quadrant (2), and product (3)
// stages. busy is always low, csr_ready always high.
// Synchronous reset clears all valid bits and loads register defaults.
// The receiver cannot stall; nothing in the pipe ever waits.
module rotating_scan_point_to_xyz import rsxyz_pkg::*; #(
   parameter int BEAMS = BEAMS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_range_mm,
   input  logic [8:0]         req_beam_index,
   input  logic [31:0]        req_frame_time,
   output logic               rsp_strobe,
   output logic signed [16:0] rsp_point_x,
   output logic signed [16:0] rsp_point_y,
   output logic signed [16:0] rsp_point_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [31:0]        csr_wdata
);

   logic [15:0] beam_step_ff, start_angle_ff;
   logic [31:0] motor_rate_ff;
   logic        direction_ff;
   logic        accept;
   angle_type   ang;
   trig_type    trig;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_step_ff   <= 16'd182;
         start_angle_ff <= '0;
         motor_rate_ff  <= '0;
         direction_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BEAM_STEP:  beam_step_ff   <= csr_wdata[15:0];
            REG_START_ANG:  start_angle_ff <= csr_wdata[15:0];
            REG_MOTOR_RATE: motor_rate_ff  <= csr_wdata;
            REG_DIRECTION:  direction_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   rsxyz_angle #(.BEAMS(BEAMS)) u_angle (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .range_mm    (req_range_mm),
      .beam_index  (req_beam_index),
      .frame_time  (req_frame_time),
      .beam_step   (beam_step_ff),
      .start_angle (start_angle_ff),
      .motor_rate  (motor_rate_ff),
      .direction   (direction_ff),
      .out         (ang)
   );

   rsxyz_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .in    (ang),
      .out   (trig)
   );

   rsxyz_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in        (trig),
      .out_valid (rsp_strobe),
      .out_x     (rsp_point_x),
      .out_y     (rsp_point_y),
      .out_z     (rsp_point_z)
   );

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("response without request");

   a_beam_out_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(32'(req_beam_index) >= BEAMS, LATENCY))
         |-> (rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0))
      else $error("beam outside frame gave nonzero point");

   a_dir_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == REG_DIRECTION) |=> direction_ff == $past(csr_wdata[0]))
      else $error("direction write lost");

endmodule

/* rtl/core/rsxyz_angle.sv */
`timescale 1ns / 1ps
module rsxyz_angle import rsxyz_pkg::*; #(
   parameter int BEAMS = BEAMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [15:0] range_mm,
   input  logic [8:0]  beam_index,
   input  logic [31:0] frame_time,
   input  logic [15:0] beam_step,
   input  logic [15:0] start_angle,
   input  logic [31:0] motor_rate,
   input  logic        direction,
   output angle_type   out
);

   logic        v1_ff, ok1_ff;
   logic [15:0] r1_ff, el1_ff, mot1_ff;
   logic [15:0] el1_in, mot1_in, az2_in;
   logic [63:0] mot_prod;
   logic [24:0] el_prod;
   logic        ok1_in;
   angle_type   out_ff;

   assign ok1_in   = 32'(beam_index) < BEAMS;
   assign el_prod  = 25'(beam_index) * 25'(beam_step);
   assign el1_in   = el_prod[15:0];
   assign mot_prod = 64'(frame_time) * 64'(motor_rate);
   assign mot1_in  = mot_prod[47:32];
   assign az2_in   = direction ? start_angle + mot1_ff : start_angle - mot1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         out_ff.valid <= v1_ff;
      end
      ok1_ff       <= ok1_in;
      r1_ff        <= range_mm;
      el1_ff       <= el1_in;
      mot1_ff      <= mot1_in;
      out_ff.ok    <= ok1_ff;
      out_ff.range <= r1_ff;
      out_ff.el    <= el1_ff;
      out_ff.az    <= az2_in;
   end

   assign out = out_ff;

endmodule

/* rtl/core/rsxyz_cordic.sv */
`timescale 1ns / 1ps
module rsxyz_cordic import rsxyz_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  angle_type in,
   output trig_type  out
);

   function automatic rot_type rot_step(input rot_type s, input int i);
      rot_type              o;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      dx = s.y >>> i;
      dy = s.x >>> i;
      if (!s.z[ZW-1]) begin
         o.x = s.x - dx;
         o.y = s.y + dy;
         o.z = s.z - $signed(ATAN_TAB[i]);
      end else begin
         o.x = s.x + dx;
         o.y = s.y - dy;
         o.z = s.z + $signed(ATAN_TAB[i]);
      end
      return o;
   endfunction

   function automatic rot_type rot_init(input logic [15:0] ang);
      rot_type o;
      o.x = CORDIC_GAIN;
      o.y = '0;
      o.z = ZW'({ang[13:0], 16'h0000});
      return o;
   endfunction

   // quadrant applied by swap and negate; x holds cos, y holds sin
   function automatic rot_type quad_map(input rot_type s, input logic [1:0] q);
      rot_type o;
      o.z = '0;
      unique case (q)
         2'd0: begin o.x = s.x;  o.y = s.y;  end
         2'd1: begin o.x = -s.y; o.y = s.x;  end
         2'd2: begin o.x = -s.x; o.y = -s.y; end
         2'd3: begin o.x = s.y;  o.y = -s.x; end
         default: begin o.x = s.x; o.y = s.y; end
      endcase
      return o;
   endfunction

   rot_type     e_ff  [CORDIC_STEPS+1];
   rot_type     a_ff  [CORDIC_STEPS+1];
   logic [1:0]  eq_ff [CORDIC_STEPS+1];
   logic [1:0]  aq_ff [CORDIC_STEPS+1];
   logic [15:0] r_ff  [CORDIC_STEPS+1];
   logic        ok_ff [CORDIC_STEPS+1];
   logic        v_ff  [CORDIC_STEPS+1];
   rot_type     e_in, a_in;
   trig_type    out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in.valid;
      end
   end

   always_ff @(posedge clock) begin
      e_ff[0]  <= rot_init(in.el);
      a_ff[0]  <= rot_init(in.az);
      eq_ff[0] <= in.el[15:14];
      aq_ff[0] <= in.az[15:14];
      r_ff[0]  <= in.range;
      ok_ff[0] <= in.ok;
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         e_ff[k+1]  <= rot_step(e_ff[k], k);
         a_ff[k+1]  <= rot_step(a_ff[k], k);
         eq_ff[k+1] <= eq_ff[k];
         aq_ff[k+1] <= aq_ff[k];
         r_ff[k+1]  <= r_ff[k];
         ok_ff[k+1] <= ok_ff[k];
      end
   end

   assign e_in = quad_map(e_ff[CORDIC_STEPS], eq_ff[CORDIC_STEPS]);
   assign a_in = quad_map(a_ff[CORDIC_STEPS], aq_ff[CORDIC_STEPS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= v_ff[CORDIC_STEPS];
      end
      out_ff.ok    <= ok_ff[CORDIC_STEPS];
      out_ff.range <= r_ff[CORDIC_STEPS];
      out_ff.ce    <= e_in.x;
      out_ff.se    <= e_in.y;
      out_ff.ca    <= a_in.x;
      out_ff.sa    <= a_in.y;
   end

   assign out = out_ff;

   a_valid_track: assert property (@(posedge clock) disable iff (reset)
      out.valid |-> $past(in.valid, CORDIC_LAT))
      else $error("cordic valid out without matching entry");

endmodule

/* rtl/core/rsxyz_scale.sv */
`timescale 1ns / 1ps
module rsxyz_scale import rsxyz_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  trig_type            in,
   output logic                out_valid,
   output logic signed [16:0]  out_x,
   output logic signed [16:0]  out_y,
   output logic signed [16:0]  out_z
);

   function automatic logic [31:0] mag32(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] a;
      a = v[XW-1] ? -v : v;
      return a[31:0];
   endfunction

   function automatic logic signed [16:0] signed_out(input logic [15:0] m, input logic neg,
                                                    input logic ok);
      logic signed [16:0] e;
      e = $signed({1'b0, m});
      if (!ok) return '0;
      return neg ? -e : e;
   endfunction

   // stage 1
   logic        v1_ff, ok1_ff, nx1_ff, ny1_ff, nz1_ff;
   logic [47:0] a1_ff, z1_ff;
   logic [31:0] ca1_ff, sa1_ff;
   // stage 2
   logic        v2_ff, ok2_ff, nx2_ff, ny2_ff, nz2_ff;
   logic [63:0] xh2_ff, xl2_ff, yh2_ff, yl2_ff;
   logic [15:0] z2_ff, z2_in;
   logic [17:0] zq;
   // stage 3
   logic        v3_ff;
   logic signed [16:0] x3_ff, y3_ff, z3_ff;
   logic [79:0] xs, ys;
   logic [19:0] xq, yq;
   logic [15:0] x3m, y3m;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      ok1_ff <= in.ok;
      nx1_ff <= in.se[XW-1] ^ in.ca[XW-1];
      ny1_ff <= in.se[XW-1] ^ in.sa[XW-1];
      nz1_ff <= in.ce[XW-1];
      a1_ff  <= 48'(in.range) * 48'(mag32(in.se));
      z1_ff  <= 48'(in.range) * 48'(mag32(in.ce));
      ca1_ff <= mag32(in.ca);
      sa1_ff <= mag32(in.sa);
   end

   // r*|s|*|c| split into two partial products over the 32-bit factor
   assign zq    = z1_ff[47:30];
   assign z2_in = (zq > 18'(COORD_MAX)) ? COORD_MAX : zq[15:0];

   always_ff @(posedge clock) begin
      ok2_ff <= ok1_ff;
      nx2_ff <= nx1_ff;
      ny2_ff <= ny1_ff;
      nz2_ff <= nz1_ff;
      xh2_ff <= 64'(a1_ff) * 64'(ca1_ff[31:16]);
      xl2_ff <= 64'(a1_ff) * 64'(ca1_ff[15:0]);
      yh2_ff <= 64'(a1_ff) * 64'(sa1_ff[31:16]);
      yl2_ff <= 64'(a1_ff) * 64'(sa1_ff[15:0]);
      z2_ff  <= z2_in;
   end

   assign xs  = {xh2_ff, 16'h0000} + 80'(xl2_ff);
   assign ys  = {yh2_ff, 16'h0000} + 80'(yl2_ff);
   assign xq  = xs[79:60];
   assign yq  = ys[79:60];
   assign x3m = (xq > 20'(COORD_MAX)) ? COORD_MAX : xq[15:0];
   assign y3m = (yq > 20'(COORD_MAX)) ? COORD_MAX : yq[15:0];

   always_ff @(posedge clock) begin
      x3_ff <= signed_out(x3m, nx2_ff, ok2_ff);
      y3_ff <= signed_out(y3m, ny2_ff, ok2_ff);
      z3_ff <= signed_out(z2_ff, nz2_ff, ok2_ff);
   end

   assign out_valid = v3_ff;
   assign out_x     = x3_ff;
   assign out_y     = y3_ff;
   assign out_z     = z3_ff;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import rsxyz_pkg::*;

   localparam int NBEAMS    = 361;
   localparam int WD_LIMIT  = 2000;
   localparam int CSR_COUNT = 4;

   typedef struct {
      logic [15:0] range_mm;
      logic [8:0]  beam;
      logic [31:0] ftime;
      bit          is_csr;
      bit          drain;
      logic [7:0]  idx;
      logic [31:0] wdata;
   } stim_type;

   typedef struct {
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic signed [16:0] z;
   } point_type;

   // Atan table for a 90 degree = 2^30 angle scale.
   localparam longint ATAN_Q30 [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   logic clock = 1'b0, reset = 1'b1;
   logic start = 1'b0, busy;
   logic [15:0] req_range_mm = '0;
   logic [8:0]  req_beam_index = '0;
   logic [31:0] req_frame_time = '0;
   logic rsp_strobe;
   logic signed [16:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic csr_valid = 1'b0, csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   rotating_scan_point_to_xyz u_dut (.*);

   // shadow registers
   logic [15:0] m_beam_step = 16'd182, m_start_ang = '0;
   logic [31:0] m_rate = '0;
   logic        m_dir = 1'b0;

   stim_type  pending_q[$];
   point_type points_q[$];
   int     errors = 0, n_items = 0, n_points = 0, n_csr = 0, idle_cycles = 0;
   bit     stim_done = 0, quiet_tail = 0;

   initial forever #2 clock = ~clock;

   function automatic longint fshift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic void trig_q30(logic [15:0] ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'(ang[13:0]) << 16;
      for (int i = 0; i < 24; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_Q30[i];
         end else begin
            x += dx; y -= dy; z += ATAN_Q30[i];
         end
      end
      case (ang[15:14])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic logic signed [16:0] clamp_mm(logic [127:0] mag, bit neg);
      logic [16:0] m;
      m = (mag > 128'd65535) ? 17'd65535 : mag[16:0];
      return neg ? -m : m;
   endfunction

   function automatic point_type project_point(logic [15:0] r, logic [8:0] b, logic [31:0] t);
      point_type p;
      logic [15:0] el, motor, az;
      logic [63:0] prod;
      longint ce, se, ca, sa;
      logic [127:0] ms, mc, msa, mca;
      p = '{default: '0};
      if (b < NBEAMS) begin
         el = 16'(b * m_beam_step);
         prod = 64'(t) * 64'(m_rate);
         motor = prod[47:32];
         az = m_dir ? 16'(m_start_ang + motor) : 16'(m_start_ang - motor);
         trig_q30(el, ce, se);
         trig_q30(az, ca, sa);
         ms = 128'(se < 0 ? -se : se);
         mc = 128'(ce < 0 ? -ce : ce);
         mca = 128'(ca < 0 ? -ca : ca);
         msa = 128'(sa < 0 ? -sa : sa);
         p.x = clamp_mm((128'(r) * ms * mca) >> 60, (se < 0) != (ca < 0));
         p.y = clamp_mm((128'(r) * ms * msa) >> 60, (se < 0) != (sa < 0));
         p.z = clamp_mm((128'(r) * mc) >> 30, ce < 0);
      end
      return p;
   endfunction

   function automatic void add_point(logic [15:0] r, logic [8:0] b, logic [31:0] t);
      stim_type s;
      s = '{r, b, t, 0, 0, '0, '0};
      pending_q.insert(pending_q.size(), s);
   endfunction

   function automatic void add_csr(logic [7:0] i, logic [31:0] d);
      stim_type s;
      s = '{'0, '0, '0, 1, 1, i, d};
      pending_q.insert(pending_q.size(), s);
   endfunction

   function automatic void add_pause();
      stim_type s;
      s = '{'0, '0, '0, 0, 1, '0, '0};
      pending_q.insert(pending_q.size(), s);
   endfunction

   // driver
   int gap = 0, settle = 0;
   always @(negedge clock) begin : drv
      logic start_nx, csr_nx;
      start_nx = start;
      csr_nx   = csr_valid;
      if (!reset) begin
         if (start && !busy) start_nx = 1'b0;
         if (csr_valid && csr_ready) csr_nx = 1'b0;
         if (pending_q.size() == 0) begin
            stim_done <= 1'b1;
            start_nx = 1'b0;
         end else if (pending_q[0].drain) begin
            // hold until the pipe has emptied, then allow for latency
            start_nx = 1'b0;
            if (points_q.size() != 0 || (start && !busy)) settle = 0;
            else if (settle < LATENCY + 4) settle++;
            else if (!(csr_valid && !csr_ready)) begin
               if (pending_q[0].is_csr) begin
                  csr_nx = 1'b1;
                  csr_index <= pending_q[0].idx;
                  csr_wdata <= pending_q[0].wdata;
                  case (pending_q[0].idx)
                     REG_BEAM_STEP:  m_beam_step = pending_q[0].wdata[15:0];
                     REG_START_ANG:  m_start_ang = pending_q[0].wdata[15:0];
                     REG_MOTOR_RATE: m_rate = pending_q[0].wdata;
                     REG_DIRECTION:  m_dir = pending_q[0].wdata[0];
                     default: ;
                  endcase
               end
               void'(pending_q.pop_front());
               settle = 0;
            end
         end else if (start && busy) begin
            // hold the item
         end else if (gap > 0) begin
            gap--;
            start_nx = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            start_nx = 1'b0;
         end else begin
            start_nx = 1'b1;
            req_range_mm <= pending_q[0].range_mm;
            req_beam_index <= pending_q[0].beam;
            req_frame_time <= pending_q[0].ftime;
            points_q.insert(points_q.size(),
                            project_point(pending_q[0].range_mm, pending_q[0].beam,
                                          pending_q[0].ftime));
            void'(pending_q.pop_front());
         end
      end
      start     <= start_nx;
      csr_valid <= csr_nx;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (start && !busy) n_items <= n_items + 1;
         if (csr_valid && csr_ready) n_csr <= n_csr + 1;
         if (rsp_strobe) begin
            n_points <= n_points + 1;
            if (points_q.size() == 0) begin
               $display("%0t: point with none expected: got (%0d, %0d, %0d)", $time,
                        rsp_point_x, rsp_point_y, rsp_point_z);
               errors++;
            end else begin
               point_type e;
               e = points_q.pop_front();
               if (e.x !== rsp_point_x) begin
                  $display("%0t: x expected %0d got %0d", $time, e.x, rsp_point_x);
                  errors++;
               end
               if (e.y !== rsp_point_y) begin
                  $display("%0t: y expected %0d got %0d", $time, e.y, rsp_point_y);
                  errors++;
               end
               if (e.z !== rsp_point_z) begin
                  $display("%0t: z expected %0d got %0d", $time, e.z, rsp_point_z);
                  errors++;
               end
            end
         end
      end
   end

   task automatic random_phase(int n, int max_range);
      for (int i = 0; i < n; i++) begin
         logic [8:0] b;
         b = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(361, 511))
                                           : 9'($urandom_range(0, 360));
         add_point(16'($urandom_range(0, max_range)), b, $urandom);
      end
   endtask

   initial begin
      // directed: default settings, field extremes, beam past the frame
      add_point(16'd0, 9'd0, 32'd0);
      add_point(16'hFFFF, 9'd0, 32'd0);
      add_point(16'hFFFF, 9'd90, 32'hFFFFFFFF);
      add_point(16'hFFFF, 9'd360, 32'd0);
      add_point(16'hFFFF, 9'd361, 32'd12345);
      add_point(16'hFFFF, 9'd511, 32'hFFFFFFFF);
      add_point(16'h5555, 9'h155, 32'h55555555);
      add_point(16'hAAAA, 9'h0AA, 32'hAAAAAAAA);
      // quadrant edges and wrap of elevation
      add_csr(REG_BEAM_STEP, 32'hFFFF_4000);
      add_csr(REG_START_ANG, 32'h0000_C000);
      add_csr(REG_MOTOR_RATE, 32'hFFFFFFFF);
      add_csr(REG_DIRECTION, 32'hFFFFFFFF);
      for (int k = 0; k < 5; k++) add_point(16'hFFFF, 9'(k), 32'(k) << 30);
      add_point(16'hFFFF, 9'd1, 32'hFFFFFFFF);
      add_csr(REG_DIRECTION, 32'd0);
      add_point(16'hFFFF, 9'd3, 32'hFFFFFFFF);
      add_point(16'd1000, 9'd2, 32'h8000_0000);
      add_csr(8'hFF, 32'h1234);
      add_point(16'd1000, 9'd1, 32'd7);
      add_csr(REG_BEAM_STEP, 32'd0);
      add_csr(REG_START_ANG, 32'hFFFF);
      add_csr(REG_MOTOR_RATE, 32'd0);
      add_point(16'hFFFF, 9'd200, 32'h1234_5678);
      add_pause();
      for (int ph = 0; ph < 6; ph++) begin
         add_csr(REG_BEAM_STEP, $urandom);
         add_csr(REG_START_ANG, $urandom);
         add_csr(REG_MOTOR_RATE, ph == 0 ? 32'hFFFFFFFF : $urandom);
         add_csr(REG_DIRECTION, $urandom);
         random_phase(120, ph == 2 ? 15 : 65535);
         if (ph == 3) add_pause();
      end
      add_csr(REG_BEAM_STEP, 32'd182);
      add_csr(REG_MOTOR_RATE, 32'd4096);
      repeat (3) add_point(16'($urandom), 9'($urandom_range(0, 360)), $urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() < 60);
      quiet_tail = 1;
   end

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (idle_cycles > WD_LIMIT) begin
            $display("rotating_scan_point_to_xyz regression: fail");
            $finish;
         end
         if (stim_done && points_q.size() == 0) begin
            repeat (LATENCY + 8) @(posedge clock);
            $display("Run covered %0d items, %0d points and %0d register writes,",
                     n_items, n_points, n_csr);
            $display("incl. angle wraps, beams past the frame and range extremes.");
            if (errors == 0 && points_q.size() == 0)
               $display("rotating_scan_point_to_xyz regression: pass");
            else
               $display("rotating_scan_point_to_xyz regression: fail");
            $finish;
         end
      end
   end
endmodule
